// File: rtl/afr_lean_protection_timer_assert.svh
// Assertion macros for the lean protection timer.
// Bodies compile away when SYNTHESIS is defined.
`ifndef AFR_LEAN_PROTECTION_TIMER_ASSERT_SVH
`define AFR_LEAN_PROTECTION_TIMER_ASSERT_SVH

`ifndef SYNTHESIS

`define AFR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lean protection assertion failed");

`define AFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lean protection assertion failed");

`else

`define AFR_ASSERT(lbl, clk, rst_n, prop)
`define AFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/afrlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afrlp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam int DELAY_STEP_MS = 100;
    localparam int DELAY_MS_W    = 15;   // 255 * 100 fits
    localparam int MAP_SCALE     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_BITS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AFR_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MAP_HALF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RPM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_THROTTLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AFR_DEV      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_DELAY    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REACT_TPS    = 3'd7;

    localparam logic [1:0] AFR_MODE_OFF    = 2'd0;
    localparam logic [1:0] AFR_MODE_FIXED  = 2'd1;
    localparam logic [1:0] AFR_MODE_TARGET = 2'd2;

    localparam logic [1:0] ENABLE_ALL = 2'b11;

    typedef struct packed {
        logic [1:0]            enable_bits;
        logic [1:0]            afr_mode;
        logic [7:0]            min_map_half;
        logic [7:0]            min_rpm_hundreds;
        logic [7:0]            min_throttle;
        logic [7:0]            afr_deviation;
        logic [DELAY_MS_W-1:0] cut_delay_ms;
        logic [7:0]            reactivate_throttle;
    } t_cfg;

    typedef struct packed {
        logic [9:0]  manifold_kpa;
        logic [7:0]  rpm_hundreds;
        logic [7:0]  throttle;
        logic [7:0]  measured_afr;
        logic [7:0]  target_afr;
        logic [31:0] now_ms;
    } t_sample;

endpackage

`default_nettype wire

// File: rtl/afrlp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module afrlp_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [afrlp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [afrlp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output afrlp_pkg::t_cfg                     o_cfg
);
    import afrlp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic [DELAY_MS_W-1:0] w_delay_ms;

    // delay kept in ms so the per-sample path is a single add
    assign w_delay_ms = DELAY_MS_W'(i_cfg_data * DELAY_STEP_MS);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ENABLE_BITS:  n_cfg.enable_bits         = i_cfg_data[1:0];
                REG_AFR_MODE:     n_cfg.afr_mode            = i_cfg_data[1:0];
                REG_MIN_MAP_HALF: n_cfg.min_map_half        = i_cfg_data;
                REG_MIN_RPM:      n_cfg.min_rpm_hundreds    = i_cfg_data;
                REG_MIN_THROTTLE: n_cfg.min_throttle        = i_cfg_data;
                REG_AFR_DEV:      n_cfg.afr_deviation       = i_cfg_data;
                REG_CUT_DELAY:    n_cfg.cut_delay_ms        = w_delay_ms;
                REG_REACT_TPS:    n_cfg.reactivate_throttle = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/afrlp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module afrlp_in_stage (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire afrlp_pkg::t_sample i_sample,
    output logic              o_valid,
    input  wire logic         i_ready,
    output afrlp_pkg::t_sample o_sample
);
    import afrlp_pkg::*;

    logic    r_vld;
    t_sample r_sample;

    // refill in the same cycle the held beat moves on
    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sample <= i_sample;
        end
    end

    assign o_valid  = r_vld;
    assign o_sample = r_sample;

endmodule

`default_nettype wire

// File: rtl/afrlp_core.sv
`timescale 1ns / 1ps
`default_nettype none

`include "afr_lean_protection_timer_assert.svh"

module afrlp_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire afrlp_pkg::t_cfg    i_cfg,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire afrlp_pkg::t_sample i_sample,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_lean_cut
);
    import afrlp_pkg::*;

    logic        r_cut;
    logic [31:0] r_deadline;
    logic        r_out_vld;
    logic        r_out_cut;

    logic        n_cut;
    logic [31:0] n_deadline;

    logic        w_fire;
    logic        w_enabled;
    logic        w_lean_afr;
    logic        w_cond;
    logic [8:0]  w_limit;
    logic [32:0] w_arm_sum;

    assign o_ready = !r_out_vld || i_ready;
    assign w_fire  = i_valid && o_ready;

    assign w_enabled = (i_cfg.enable_bits == ENABLE_ALL) && (i_cfg.afr_mode != AFR_MODE_OFF);

    // target + deviation is a 9-bit sum, no wrap
    assign w_limit = {1'b0, i_sample.target_afr} + {1'b0, i_cfg.afr_deviation};

    always_comb begin
        unique case (i_cfg.afr_mode)
            AFR_MODE_FIXED:  w_lean_afr = i_sample.measured_afr >= i_cfg.afr_deviation;
            AFR_MODE_TARGET: w_lean_afr = {1'b0, i_sample.measured_afr} >= w_limit;
            default:         w_lean_afr = 1'b0;
        endcase
    end

    assign w_cond = (i_sample.manifold_kpa >= 10'(i_cfg.min_map_half * MAP_SCALE))
                 && (i_sample.rpm_hundreds >= i_cfg.min_rpm_hundreds)
                 && (i_sample.throttle >= i_cfg.min_throttle)
                 && w_lean_afr;

    assign w_arm_sum = {1'b0, i_sample.now_ms} + 33'(i_cfg.cut_delay_ms);

    always_comb begin
        n_cut      = r_cut;
        n_deadline = r_deadline;
        if (w_enabled) begin
            if (w_cond) begin
                if (r_deadline == '0) begin
                    n_deadline = w_arm_sum[31:0];
                    // now >= now + delay (mod 2^32) only for zero delay or a wrap
                    n_cut = (i_cfg.cut_delay_ms == '0) || w_arm_sum[32];
                end else begin
                    n_cut = i_sample.now_ms >= r_deadline;
                end
            end else begin
                n_deadline = '0;
            end
            if (i_sample.throttle <= i_cfg.reactivate_throttle) begin
                n_cut      = 1'b0;
                n_deadline = '0;
            end
        end else begin
            n_cut = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut      <= 1'b0;
            r_deadline <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_fire) begin
                r_cut      <= n_cut;
                r_deadline <= n_deadline;
            end
            if (o_ready) begin
                r_out_vld <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_cut <= n_cut;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_lean_cut = r_out_cut;

    `AFR_ASSERT_IMPL(a_disabled_clears, i_clk, i_rst_n, w_fire && !w_enabled, ##1 !r_cut)
    `AFR_ASSERT_IMPL(a_cut_rise_on_beat, i_clk, i_rst_n, $past(i_rst_n) && $rose(r_cut), $past(w_fire))
    `AFR_ASSERT_IMPL(a_deadline_on_beat, i_clk, i_rst_n, $past(i_rst_n) && (r_deadline != $past(r_deadline)), $past(w_fire))
    `AFR_ASSERT(a_result_follows_state, i_clk, i_rst_n, w_fire |=> (r_out_vld && (r_out_cut == r_cut)))

endmodule

`default_nettype wire

// File: rtl/afr_lean_protection_timer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                       Payload
// in        i_in_valid / o_in_ready         manifold, rpm, throttle, afr, target, now_ms
// out       o_out_valid / i_out_ready       o_lean_cut
// cfg       i_cfg_we (no wait)              i_cfg_idx, i_cfg_data
//
// Path from input beat to result: input register, then the condition
// check, deadline add and compare feed the state and result registers.
// One sample per cycle sustained while the output is not stalled; both stages refill as they drain.
// Synchronous active-low reset clears valid flags, cut state, deadline and
// config; sample and result data registers are not reset.
// A stalled output holds its beat and backs up into the input register.

module afr_lean_protection_timer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [9:0]                       i_manifold_kpa,
    input  wire logic [7:0]                       i_rpm_hundreds,
    input  wire logic [7:0]                       i_throttle,
    input  wire logic [7:0]                       i_measured_afr,
    input  wire logic [7:0]                       i_target_afr,
    input  wire logic [31:0]                      i_now_ms,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_lean_cut,
    input  wire logic                             i_cfg_we,
    input  wire logic [afrlp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [afrlp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import afrlp_pkg::*;

    t_cfg    w_cfg;
    t_sample w_in_sample;
    t_sample w_st_sample;
    logic    w_st_valid;
    logic    w_st_ready;

    assign w_in_sample.manifold_kpa = i_manifold_kpa;
    assign w_in_sample.rpm_hundreds = i_rpm_hundreds;
    assign w_in_sample.throttle     = i_throttle;
    assign w_in_sample.measured_afr = i_measured_afr;
    assign w_in_sample.target_afr   = i_target_afr;
    assign w_in_sample.now_ms       = i_now_ms;

    afrlp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    afrlp_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_sample (w_in_sample),
        .o_valid  (w_st_valid),
        .i_ready  (w_st_ready),
        .o_sample (w_st_sample)
    );

    afrlp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (w_st_valid),
        .o_ready    (w_st_ready),
        .i_sample   (w_st_sample),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_lean_cut (o_lean_cut)
    );

endmodule

`default_nettype wire
